@@ hdl/bctc_pkg.sv @@
`timescale 1ns / 1ps
package bctc_pkg;

	localparam int RAW_W   = 24;
	localparam int TEMP_W  = 24;
	localparam int PRESS_W = 23;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 2;
	localparam int ACC_W   = 112;

	localparam logic [IDX_W-1:0] REG_TEMP_TRIM = 2'd0;
	localparam logic [IDX_W-1:0] REG_PRESS_A   = 2'd1;
	localparam logic [IDX_W-1:0] REG_PRESS_B   = 2'd2;

	// raw trim fields, signedness applied where used
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [7:0]  t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [7:0]  p3;
		logic [7:0]  p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [7:0]  p7;
		logic [7:0]  p8;
		logic [15:0] p9;
		logic [7:0]  p10;
		logic [7:0]  p11;
	} trim_t;

	// aligned pressure terms at 2^-85 Pa, two's complement
	typedef struct packed {
		logic [ACC_W-1:0] t_p5;
		logic [ACC_W-1:0] t_p6;
		logic [ACC_W-1:0] t_p7;
		logic [ACC_W-1:0] t_p8;
		logic [ACC_W-1:0] t_p1;
		logic [ACC_W-1:0] t_p2;
		logic [ACC_W-1:0] t_p3;
		logic [ACC_W-1:0] t_p9;
		logic [ACC_W-1:0] t_p10;
		logic [ACC_W-1:0] t_p11;
		logic [ACC_W-1:0] d00;
		logic [ACC_W-1:0] d01;
		logic [ACC_W-1:0] d10;
		logic [ACC_W-1:0] d11;
	} pterm_t;

	function automatic trim_t unpack_trims(logic [39:0] tw, logic [63:0] wa, logic [63:0] wb);
		trim_t r;
		r.t1  = tw[15:0];
		r.t2  = tw[31:16];
		r.t3  = tw[39:32];
		r.p1  = wa[15:0];
		r.p2  = wa[31:16];
		r.p3  = wa[39:32];
		r.p4  = wa[47:40];
		r.p5  = wa[63:48];
		r.p6  = wb[15:0];
		r.p7  = wb[23:16];
		r.p8  = wb[31:24];
		r.p9  = wb[47:32];
		r.p10 = wb[55:48];
		r.p11 = wb[63:56];
		return r;
	endfunction

endpackage

@@ hdl/baro_trim_compensation_unit.sv @@
`timescale 1ns / 1ps
// Barometric trim compensation. Takes one word of raw 24-bit temperature and
// pressure conversions per clock and returns compensated temperature (signed
// Q16 degrees C, saturated) and pressure (1/64 Pa, clamped to 0..2^23-1),
// computed exactly in fixed point from the datasheet polynomials. Sustained
// rate is one word per cycle unless the output stalls, through the ten-stage
// multiply/add pipeline (4 stages temperature, 3 stages products, 3 stages
// sum/round). The whole pipeline advances on one enable, so an output stall
// freezes every stage and drops in_ready. Trim registers are plain writes and
// must only change while no word is in flight.
module baro_trim_compensation_unit import bctc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [RAW_W-1:0]         raw_temp,
	input  logic [RAW_W-1:0]         raw_press,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [TEMP_W-1:0] comp_temp,
	output logic [PRESS_W-1:0]       comp_press,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	logic [39:0]      temp_trim_q;
	logic [CFG_W-1:0] press_a_q;
	logic [CFG_W-1:0] press_b_q;
	trim_t            trims;

	logic                     en;
	logic                     t_vld, m_vld;
	logic signed [TEMP_W-1:0] t_tq, m_tq;
	logic [RAW_W-1:0]         t_up;
	pterm_t                   m_terms;

	// trim registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q <= '0;
			press_a_q   <= '0;
			press_b_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_TRIM: temp_trim_q <= cfg_data[39:0];
				REG_PRESS_A:   press_a_q   <= cfg_data;
				REG_PRESS_B:   press_b_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign trims = unpack_trims(temp_trim_q, press_a_q, press_b_q);

	// global advance: move when the output slot is empty or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	bctc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (in_valid),
		.raw_temp  (raw_temp),
		.raw_press (raw_press),
		.trims     (trims),
		.vld_out   (t_vld),
		.tq        (t_tq),
		.up        (t_up)
	);

	bctc_pmul u_pmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (t_vld),
		.tq      (t_tq),
		.up      (t_up),
		.trims   (trims),
		.vld_out (m_vld),
		.tq_out  (m_tq),
		.terms   (m_terms)
	);

	bctc_psum u_psum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (m_vld),
		.tq         (m_tq),
		.terms      (m_terms),
		.vld_out    (out_valid),
		.comp_temp  (comp_temp),
		.comp_press (comp_press)
	);

endmodule

@@ hdl/bctc_temp.sv @@
`timescale 1ns / 1ps
module bctc_temp import bctc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic [RAW_W-1:0]         raw_temp,
	input  logic [RAW_W-1:0]         raw_press,
	input  trim_t                    trims,
	output logic                     vld_out,
	output logic signed [TEMP_W-1:0] tq,
	output logic [RAW_W-1:0]         up
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic signed [24:0] d_s1;
	logic [RAW_W-1:0]   up_s1, up_s2, up_s3, up_s4;
	logic signed [41:0] dt2_s2, dt2_s3;
	logic signed [49:0] dd_s2;
	logic signed [57:0] ddt3_s3;
	logic signed [TEMP_W-1:0] tq_s4;

	logic signed [24:0] d_c;
	logic signed [61:0] s_c;
	logic signed [29:0] q_c;
	logic signed [TEMP_W-1:0] tq_c;

	assign d_c = $signed({1'b0, raw_temp}) - $signed({1'b0, trims.t1, 8'd0});

	// t*2^48 exact, round half up to Q16, saturate
	always_comb begin
		s_c = (62'(dt2_s3) <<< 18) + 62'(ddt3_s3) + 62'sd2147483648;
		q_c = 30'(s_c >>> 32);
		if (q_c > 30'sd8388607) begin
			tq_c = 24'sh7FFFFF;
		end else if (q_c < -30'sd8388608) begin
			tq_c = 24'sh800000;
		end else begin
			tq_c = q_c[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d_c;
			up_s1   <= raw_press;
			dt2_s2  <= d_s1 * $signed({1'b0, trims.t2});
			dd_s2   <= d_s1 * d_s1;
			up_s2   <= up_s1;
			ddt3_s3 <= dd_s2 * $signed(trims.t3);
			dt2_s3  <= dt2_s2;
			up_s3   <= up_s2;
			tq_s4   <= tq_c;
			up_s4   <= up_s3;
		end
	end

	assign vld_out = v_s4;
	assign tq      = tq_s4;
	assign up      = up_s4;

endmodule

@@ hdl/bctc_pmul.sv @@
`timescale 1ns / 1ps
module bctc_pmul import bctc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic signed [TEMP_W-1:0] tq,
	input  logic [RAW_W-1:0]         up,
	input  trim_t                    trims,
	output logic                     vld_out,
	output logic signed [TEMP_W-1:0] tq_out,
	output pterm_t                   terms
);

	logic v_s5, v_s6, v_s7;

	logic signed [24:0] up_c;
	logic signed [17:0] p1m_c, p2m_c;
	assign up_c  = $signed({1'b0, up});
	assign p1m_c = 18'($signed(trims.p1)) - 18'sd16384;
	assign p2m_c = 18'($signed(trims.p2)) - 18'sd16384;

	// stage 5: first-level products
	logic signed [47:0] tq2_s5;
	logic signed [40:0] m6_s5;
	logic signed [31:0] m7_s5, m8_s5, m10_s5;
	logic signed [42:0] mu1_s5, mu2_s5;
	logic signed [32:0] mu3_s5, mu4_s5, mu11_s5;
	logic [47:0]        up2_s5;
	logic signed [TEMP_W-1:0] tq_s5, tq_s6, tq_s7;

	// stage 6: second-level products, wide operands split in halves
	logic signed [55:0] a3_s6, b4hi_s6;
	logic signed [56:0] b4lo_s6, b7hi_s6, c8_s6, b10lo_s6, b10hi_s6;
	logic signed [66:0] a6_s6;
	logic signed [57:0] b7lo_s6, b11lo_s6, b11hi_s6;
	logic signed [64:0] a9_s6;
	logic signed [40:0] m6_s6;
	logic signed [42:0] mu1_s6;
	logic signed [47:0] tq2_s6;

	pterm_t terms_s7;

	logic signed [24:0] tlo_c, ulo_c, uhi_c, tlo6_c;
	logic signed [23:0] thi_c, thi6_c;
	logic signed [28:0] c8lo_c, c8hi_c;
	logic signed [ACC_W-1:0] t_p8_c, t_p3_c, t_p10_c, t_p11_c;

	// tq^2 is never negative, so its halves are plain magnitudes
	assign tlo_c  = $signed({1'b0, tq2_s5[23:0]});
	assign thi_c  = $signed({1'b0, tq2_s5[46:24]});
	assign ulo_c  = $signed({1'b0, up2_s5[23:0]});
	assign uhi_c  = $signed({1'b0, up2_s5[47:24]});
	assign tlo6_c = $signed({1'b0, tq2_s6[23:0]});
	assign thi6_c = $signed({1'b0, tq2_s6[46:24]});
	assign c8lo_c = $signed({1'b0, c8_s6[27:0]});
	assign c8hi_c = $signed(c8_s6[56:28]);

	always_comb begin
		t_p8_c  = ((ACC_W'(b4hi_s6) <<< 24) + ACC_W'(b4lo_s6)) <<< 22;
		t_p3_c  = ((ACC_W'(b7hi_s6) <<< 24) + ACC_W'(b7lo_s6)) <<< 21;
		t_p10_c = ((ACC_W'(b10hi_s6) <<< 24) + ACC_W'(b10lo_s6)) <<< 21;
		t_p11_c = ((ACC_W'(b11hi_s6) <<< 24) + ACC_W'(b11lo_s6)) <<< 20;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= vld_in;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tq2_s5  <= tq * tq;
			m6_s5   <= $signed({1'b0, trims.p6}) * tq;
			m7_s5   <= $signed(trims.p7) * tq;
			m8_s5   <= $signed(trims.p8) * tq;
			m10_s5  <= $signed(trims.p10) * tq;
			mu1_s5  <= up_c * p1m_c;
			mu2_s5  <= up_c * p2m_c;
			mu3_s5  <= up_c * $signed(trims.p3);
			mu4_s5  <= up_c * $signed(trims.p4);
			mu11_s5 <= up_c * $signed(trims.p11);
			up2_s5  <= up * up;
			tq_s5   <= tq;

			a3_s6    <= m7_s5 * tq_s5;
			b4lo_s6  <= m8_s5 * tlo_c;
			b4hi_s6  <= m8_s5 * thi_c;
			a6_s6    <= mu2_s5 * tq_s5;
			b7lo_s6  <= mu3_s5 * tlo_c;
			b7hi_s6  <= mu3_s5 * thi_c;
			c8_s6    <= mu4_s5 * tq_s5;
			a9_s6    <= $signed({1'b0, up2_s5}) * $signed(trims.p9);
			b10lo_s6 <= m10_s5 * ulo_c;
			b10hi_s6 <= m10_s5 * uhi_c;
			b11lo_s6 <= mu11_s5 * ulo_c;
			b11hi_s6 <= mu11_s5 * uhi_c;
			m6_s6    <= m6_s5;
			mu1_s6   <= mu1_s5;
			tq2_s6   <= tq2_s5;
			tq_s6    <= tq_s5;

			terms_s7.t_p5  <= ACC_W'(trims.p5) << 88;
			terms_s7.t_p6  <= ACC_W'(m6_s6) <<< 63;
			terms_s7.t_p7  <= ACC_W'(a3_s6) <<< 45;
			terms_s7.t_p8  <= t_p8_c;
			terms_s7.t_p1  <= ACC_W'(mu1_s6) <<< 65;
			terms_s7.t_p2  <= ACC_W'(a6_s6) <<< 40;
			terms_s7.t_p3  <= t_p3_c;
			terms_s7.t_p9  <= ACC_W'(a9_s6) <<< 37;
			terms_s7.t_p10 <= t_p10_c;
			terms_s7.t_p11 <= t_p11_c;
			// up*P4*t^3 partials
			terms_s7.d00   <= ACC_W'(c8lo_c * tlo6_c);
			terms_s7.d01   <= ACC_W'(c8lo_c * thi6_c) <<< 24;
			terms_s7.d10   <= ACC_W'(c8hi_c * tlo6_c) <<< 28;
			terms_s7.d11   <= ACC_W'(c8hi_c * thi6_c) <<< 52;
			tq_s7          <= tq_s6;
		end
	end

	assign vld_out = v_s7;
	assign tq_out  = tq_s7;
	assign terms   = terms_s7;

endmodule

@@ hdl/bctc_psum.sv @@
`timescale 1ns / 1ps
module bctc_psum import bctc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_in,
	input  logic signed [TEMP_W-1:0] tq,
	input  pterm_t                   terms,
	output logic                     vld_out,
	output logic signed [TEMP_W-1:0] comp_temp,
	output logic [PRESS_W-1:0]       comp_press
);

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << 78;

	logic v_s8, v_s9, v_s10;
	logic [ACC_W-1:0] g1_s8, g2_s8, g3_s8, g4_s8, acc_s9;
	logic signed [TEMP_W-1:0] tq_s8, tq_s9, tq_s10;
	logic [PRESS_W-1:0] pr_s10;

	logic [31:0]        q_c;
	logic [PRESS_W-1:0] pr_c;

	assign q_c = acc_s9[ACC_W-2:79];

	always_comb begin
		if (acc_s9[ACC_W-1]) begin
			pr_c = '0;
		end else if (|q_c[31:PRESS_W]) begin
			pr_c = '1;
		end else begin
			pr_c = q_c[PRESS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s8  <= vld_in;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g1_s8  <= terms.t_p5 + terms.t_p6 + terms.t_p7 + terms.t_p8;
			g2_s8  <= terms.t_p1 + terms.t_p2 + terms.t_p3;
			g3_s8  <= terms.t_p9 + terms.t_p10 + terms.t_p11;
			g4_s8  <= terms.d00 + terms.d01 + terms.d10 + terms.d11;
			tq_s8  <= tq;
			acc_s9 <= g1_s8 + g2_s8 + g3_s8 + g4_s8 + ROUND_HALF;
			tq_s9  <= tq_s8;
			pr_s10 <= pr_c;
			tq_s10 <= tq_s9;
		end
	end

	assign vld_out    = v_s10;
	assign comp_temp  = tq_s10;
	assign comp_press = pr_s10;

endmodule

@@ hdl/bctc_checker.sv @@
`timescale 1ns / 1ps
module bctc_checker import bctc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [RAW_W-1:0]         raw_temp,
	input logic [RAW_W-1:0]         raw_press,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [TEMP_W-1:0] comp_temp,
	input logic [PRESS_W-1:0]       comp_press,
	input logic                     cfg_we,
	input logic [IDX_W-1:0]         cfg_index,
	input logic [CFG_W-1:0]         cfg_data
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(comp_temp) && $stable(comp_press))
		else $error("output word changed while stalled");

	// waiting input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(raw_temp) && $stable(raw_press))
		else $error("input word changed while waiting");

	// input side follows the pipeline advance
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not track pipeline advance");

	// trim writes carry known index and data
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown({cfg_index, cfg_data}))
		else $error("trim write with unknown index or data");

	// reset empties the pipeline
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid high during reset");

endmodule

bind baro_trim_compensation_unit bctc_checker u_chk (.*);

@@ sim/baro_trim_compensation_unit_tb.sv @@
`timescale 1ns / 1ps
module baro_trim_compensation_unit_tb;
	import bctc_pkg::*;

	localparam int LATENCY   = 10;
	localparam int STALL_MAX = 3000;	// cycles with no word moving on either side

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [RAW_W-1:0]         raw_temp;
	logic [RAW_W-1:0]         raw_press;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [TEMP_W-1:0] comp_temp;
	logic [PRESS_W-1:0]       comp_press;
	logic                     cfg_we;
	logic [IDX_W-1:0]         cfg_index;
	logic [CFG_W-1:0]         cfg_data;

	baro_trim_compensation_unit dut (.*);

	// expected compensated readings, oldest first
	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [PRESS_W-1:0]       press;
	} reading_t;

	reading_t pending_readings[$];

	// testbench copy of the trim registers
	logic [39:0] temp_trims;
	logic [63:0] press_trims_a;
	logic [63:0] press_trims_b;

	int  errors;
	bit  quiet;		// no idling on either side
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// signed product of two 64-bit operands, aligned to the 2^-85 Pa grid
	function automatic logic signed [127:0] aligned_product(longint a, longint b,
			int unsigned k);
		logic signed [127:0] x, y;
		x = a;
		y = b;
		return (x * y) <<< k;
	endfunction

	function automatic reading_t compensate(logic [RAW_W-1:0] ut_raw, logic [RAW_W-1:0] up_raw);
		longint ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
		longint d, s, tq, tq2, up2;
		logic signed [127:0] acc;
		logic [127:0] mag;
		reading_t r;
		ut  = ut_raw;
		up  = up_raw;
		t1  = temp_trims[15:0];
		t2  = temp_trims[31:16];
		t3  = $signed(temp_trims[39:32]);
		p1  = $signed(press_trims_a[15:0]);
		p2  = $signed(press_trims_a[31:16]);
		p3  = $signed(press_trims_a[39:32]);
		p4  = $signed(press_trims_a[47:40]);
		p5  = press_trims_a[63:48];
		p6  = press_trims_b[15:0];
		p7  = $signed(press_trims_b[23:16]);
		p8  = $signed(press_trims_b[31:24]);
		p9  = $signed(press_trims_b[47:32]);
		p10 = $signed(press_trims_b[55:48]);
		p11 = $signed(press_trims_b[63:56]);

		// temperature exact at 2^-48, round half up to Q16, saturate
		d  = ut - t1 * 256;
		s  = d * t2 * 262144 + d * d * t3;
		tq = (s + (64'sd1 <<< 31)) >>> 32;
		if (tq > 8388607)
			tq = 8388607;
		if (tq < -8388608)
			tq = -8388608;

		// pressure: exact sum at 2^-85 Pa using the saturated temperature
		tq2 = tq * tq;
		up2 = up * up;
		acc = aligned_product(p5, 1, 88)
			+ aligned_product(p6, tq, 63)
			+ aligned_product(p7, tq2, 45)
			+ aligned_product(p8 * tq2, tq, 22)
			+ aligned_product(up, p1 - 16384, 65)
			+ aligned_product(up * (p2 - 16384), tq, 40)
			+ aligned_product(up * p3, tq2, 21)
			+ aligned_product(up * p4 * tq, tq2, 0)
			+ aligned_product(up2, p9, 37)
			+ aligned_product(up2, p10 * tq, 21)
			+ aligned_product(up2 * p11, up, 20);
		acc = acc + (128'sd1 <<< 78);	// half of an output LSB
		if (acc[127]) begin
			r.press = '0;
		end else begin
			mag = acc >> 79;
			r.press = (mag > 128'd8388607) ? 23'h7FFFFF : mag[PRESS_W-1:0];
		end
		r.temp = tq[TEMP_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch @%0t: %s", $time, msg);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected word temp=%0d press=%0d",
					comp_temp, comp_press));
			end else begin
				want = pending_readings.pop_front();
				if (comp_temp !== want.temp)
					report_mismatch($sformatf("comp_temp got %0d want %0d",
						comp_temp, want.temp));
				if (comp_press !== want.press)
					report_mismatch($sformatf("comp_press got %0d want %0d",
						comp_press, want.press));
			end
		end
	end

	// receiver: random stall bursts unless quiet
	initial begin
		out_ready <= 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles where no word moves
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("timeout: nothing moving");
			$display("FAIL");
			$finish;
		end
	end

	// one word into the block; expectation recorded at acceptance
	task automatic send_word(logic [RAW_W-1:0] ut, logic [RAW_W-1:0] up);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		raw_temp  <= ut;
		raw_press <= up;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(compensate(ut, up));
	endtask

	// let the pipeline empty, then give it its latency again
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_trims(logic [39:0] tw, logic [63:0] wa, logic [63:0] wb);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TEMP_TRIM;
		cfg_data  <= {24'd0, tw};
		@(posedge clk);
		cfg_index <= REG_PRESS_A;
		cfg_data  <= wa;
		@(posedge clk);
		cfg_index <= REG_PRESS_B;
		cfg_data  <= wb;
		@(posedge clk);
		cfg_we    <= 1'b0;
		temp_trims    = tw;
		press_trims_a = wa;
		press_trims_b = wb;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// raw temperature near the T1 offset so the quadratic stays in range
	function automatic logic [RAW_W-1:0] near_offset_temp();
		int base;
		base = int'(temp_trims[15:0]) * 256 + $signed($urandom_range(0, 1048575)) - 524288;
		if (base < 0)
			base = 0;
		if (base > 16777215)
			base = 16777215;
		return base[RAW_W-1:0];
	endfunction

	// trims zero after reset: pressure rests on P1 = 0 alone
	task automatic test_reset_trims();
		temp_trims    = '0;
		press_trims_a = '0;
		press_trims_b = '0;
		send_word('0, '0);
		send_word('1, '1);
		send_word(24'h800000, 24'h7FFFFF);
		drain();
	endtask

	// typical datasheet-like trims, field extremes
	task automatic test_directed();
		write_trims({8'hF9, 16'd19000, 16'd27500},
			{16'd19800, 8'd3, 8'hF6, 16'hF000, 16'hFC00},
			{8'hF3, 8'd10, 16'd12000, 8'hF4, 8'd20, 16'd23000});
		send_word(24'd0, 24'd0);
		send_word(24'hFFFFFF, 24'hFFFFFF);
		send_word(24'hFFFFFF, 24'd0);
		send_word(24'd0, 24'hFFFFFF);
		send_word(24'(27500 * 256), 24'h6A0000);	// zero temperature offset
		send_word(24'(27500 * 256 + 1), 24'h555555);
		send_word(24'h6C0000, 24'hAAAAAA);
		send_word(24'h6B0000, 24'h700000);
		drain();
		// all trims at their maximum raw value
		write_trims('1, '1, '1);
		send_word(24'd0, 24'd0);
		send_word(24'hFFFFFF, 24'hFFFFFF);
		send_word(24'h123456, 24'hFEDCBA);
		drain();
		// most-negative signed trims, large positive unsigned ones but T1 at zero
		write_trims({8'h80, 16'hFFFF, 16'h0000},
			{16'hFFFF, 8'h80, 8'h80, 16'h8000, 16'h8000},
			{8'h80, 8'h80, 16'h8000, 8'h80, 8'h80, 16'hFFFF});
		send_word(24'h000001, 24'hFFFFFF);
		send_word(24'hFFFFFF, 24'h000001);
		send_word(24'h800000, 24'h800000);
		drain();
	endtask

	// random trims per phase, mostly realistic raw temperatures
	task automatic test_random(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			write_trims({8'($urandom_range(0, 255)), $urandom()}, rand64(), rand64());
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(0, 3) != 0)
					send_word(near_offset_temp(), 24'($urandom()));
				else
					send_word(24'($urandom()), 24'($urandom()));
			end
			drain();
		end
	endtask

	initial begin
		errors    = 0;
		quiet     = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		raw_temp  <= '0;
		raw_press <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_TEMP_TRIM;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_trims();
		test_directed();
		test_random(5, 100);
		quiet = 1;	// back-to-back tail
		test_random(1, 80);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ baro_trim_compensation_unit.f @@
hdl/bctc_pkg.sv
hdl/bctc_temp.sv
hdl/bctc_pmul.sv
hdl/bctc_psum.sv
hdl/baro_trim_compensation_unit.sv
hdl/bctc_checker.sv
sim/baro_trim_compensation_unit_tb.sv
